>>> rtl/p5td_pkg.sv
`default_nettype none
package p5td_pkg;

   localparam int unsigned CODE_W      = 5;
   localparam int unsigned CHAR_W      = 7;
   localparam int unsigned CODES       = 3;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [CODE_W-1:0] CODE_TOGGLE = 5'd31;
   localparam logic [CHAR_W-1:0] CHAR_TERM   = 7'd0;

   // code n sits at bits 8*(30-n) +: 8 of each row
   localparam logic [8*31-1:0] ROW_LOWER = " abcdefghijklmnopqrstuvwxyz?:'!";
   localparam logic [8*31-1:0] ROW_ALT   = " 0123456789abcdefghilmnorstuwy-";

   // mask bits 0..2: characters of the three codes; bit 3: terminator
   typedef struct packed {
      logic [CODES:0]                  mask;
      logic [CODES-1:0][CHAR_W-1:0]    chars;
   } entry_type;

   function automatic logic [CHAR_W-1:0] char_lookup(input logic set_sel,
                                                     input logic [CODE_W-1:0] code);
      logic [7:0] b;
      b = 8'd0;
      if (code != CODE_TOGGLE) begin
         if (set_sel) begin
            b = ROW_ALT[8*(30-int'(code)) +: 8];
         end else begin
            b = ROW_LOWER[8*(30-int'(code)) +: 8];
         end
      end
      return b[CHAR_W-1:0];
   endfunction

endpackage
`default_nettype wire

>>> rtl/packed_5bit_text_decoder_core.sv
// channel | dir | beat                       | fields (lsb up)
// req_    | in  | one packed text word       | tdata: low_byte[7:0], high_byte[15:8]
// rsp_    | out | one character / terminator | tdata: out_char[6:0]; tlast: end_of_string;
//         |     |                            | tuser: last_of_item
// A word is decoded in the cycle it is accepted and, unless it yields no beat,
// parked in a 4-entry queue. The output stage sends one beat per cycle while
// rsp_tready is high; a word gives its characters plus its terminator (0 to 4, 3 typical).
// With the queue empty, a first beat passes the queue, current entry and output register.
// Input stalls only when the queue is full; output stalls block input only via the queue.
// Synchronous reset clears the queue, output stage and character-set flag.
`default_nettype none
module packed_5bit_text_decoder_core (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [15:0]   req_tdata,   // low_byte[7:0], high_byte[15:8]
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [7:0]         rsp_tdata,   // out_char[6:0], zero[7]
   output logic               rsp_tlast,   // end_of_string
   output logic               rsp_tuser    // last_of_item
);
   import p5td_pkg::*;

   entry_type            f_entry, q_head;
   logic                 f_push, q_full, q_valid, b_pop, accept;
   logic [CHAR_W-1:0]    b_char;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   p5td_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .word   (req_tdata),
      .entry  (f_entry),
      .push   (f_push)
   );

   p5td_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (f_push),
      .push_entry (f_entry),
      .full       (q_full),
      .pop        (b_pop),
      .not_empty  (q_valid),
      .head       (q_head)
   );

   p5td_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .pop       (b_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_char  (b_char),
      .rsp_eos   (rsp_tlast),
      .rsp_last  (rsp_tuser)
   );

   assign rsp_tdata = {1'b0, b_char};

endmodule
`default_nettype wire

>>> rtl/p5td_front.sv
`default_nettype none
module p5td_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [15:0]         word,
   output p5td_pkg::entry_type      entry,
   output logic                     push
);
   import p5td_pkg::*;

   logic                   set_ff;
   logic                   set_in;
   logic [CODE_W-1:0]      code;
   logic                   run_set;

   always_comb begin
      run_set = set_ff;
      code    = '0;
      entry   = '0;
      for (int i = 0; i < CODES; i++) begin
         code = word[CODE_W*i +: CODE_W];
         if (code == CODE_TOGGLE) begin
            run_set = ~run_set;
         end else begin
            entry.mask[i]  = 1'b1;
            entry.chars[i] = char_lookup(run_set, code);
         end
      end
      entry.mask[CODES] = word[15];
      push   = accept && (entry.mask != '0);
      set_in = accept ? run_set : set_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_ff <= 1'b0;
      end else begin
         set_ff <= set_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/p5td_queue.sv
`default_nettype none
module p5td_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire p5td_pkg::entry_type push_entry,
   output logic                     full,
   input  wire logic                pop,
   output logic                     not_empty,
   output p5td_pkg::entry_type      head
);
   import p5td_pkg::*;

   entry_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]      count_ff, count_in;
   logic                 do_push, do_pop;

   always_comb begin
      full      = (count_ff == QUEUE_DEPTH[QPTR_W:0]);
      not_empty = (count_ff != '0);
      head      = mem_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && not_empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/p5td_back.sv
`default_nettype none
module p5td_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       q_valid,
   input  wire p5td_pkg::entry_type        q_head,
   output logic                            pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [p5td_pkg::CHAR_W-1:0]     rsp_char,
   output logic                            rsp_eos,
   output logic                            rsp_last
);
   import p5td_pkg::*;

   entry_type            cur_ff, cur_in;
   logic                 valid_ff, valid_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic                 eos_ff, eos_in;
   logic                 last_ff, last_in;
   logic                 out_free;
   logic [CODES:0]       low, rest;

   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff && !rsp_ready;
      char_in  = char_ff;
      eos_in   = eos_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      out_free = !valid_ff || rsp_ready;
      low      = cur_ff.mask & (~cur_ff.mask + 1'b1);
      rest     = cur_ff.mask;
      if (out_free && (cur_ff.mask != '0)) begin
         rest     = cur_ff.mask & ~low;
         valid_in = 1'b1;
         eos_in   = low[CODES];
         last_in  = (rest == '0);
         if (low[0]) begin
            char_in = cur_ff.chars[0];
         end else if (low[1]) begin
            char_in = cur_ff.chars[1];
         end else if (low[2]) begin
            char_in = cur_ff.chars[2];
         end else begin
            char_in = CHAR_TERM;
         end
      end
      cur_in.mask = rest;
      if ((rest == '0) && q_valid) begin
         pop    = 1'b1;
         cur_in = q_head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cur_ff   <= cur_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      eos_ff  <= eos_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_char  = char_ff;
   assign rsp_eos   = eos_ff;
   assign rsp_last  = last_ff;

endmodule
`default_nettype wire

>>> tb/tb_packed_5bit_text_decoder_core.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_packed_5bit_text_decoder_core;
   import p5td_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              eos;
      logic              last;
   } text_beat_type;

   class text_scoreboard;
      text_beat_type expected_q[$];
      bit            char_set;
      int            errors;
      int            beats_checked;
      int            terminators;
      string         lower_row;
      string         alt_row;

      function new();
         lower_row     = " abcdefghijklmnopqrstuvwxyz?:'!";
         alt_row       = " 0123456789abcdefghilmnorstuwy-";
         char_set      = 1'b0;
         errors        = 0;
         beats_checked = 0;
         terminators   = 0;
      endfunction

      // expected beats of one accepted word, updating the set flag
      function void note_word(logic [15:0] word);
         logic [CODE_W-1:0] code;
         text_beat_type     b;
         byte               glyph;
         int                n;
         n = 0;
         for (int i = 0; i < CODES; i++) begin
            code = word[CODE_W*i +: CODE_W];
            if (code == CODE_TOGGLE) begin
               char_set = ~char_set;
            end else begin
               glyph  = char_set ? alt_row[code] : lower_row[code];
               b.ch   = glyph[CHAR_W-1:0];
               b.eos  = 1'b0;
               b.last = 1'b0;
               expected_q.push_back(b);
               n++;
            end
         end
         if (word[15]) begin
            b.ch   = CHAR_TERM;
            b.eos  = 1'b1;
            b.last = 1'b0;
            expected_q.push_back(b);
            n++;
         end
         if (n > 0) begin
            expected_q[expected_q.size()-1].last = 1'b1;
         end
      endfunction

      function void check_beat(logic [7:0] data, logic tl, logic tu);
         text_beat_type b;
         beats_checked++;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("unexpected beat: tdata %02h tlast %0b tuser %0b", data, tl, tu);
            end
            return;
         end
         b = expected_q.pop_front();
         if (b.eos) begin
            terminators++;
         end
         if (data !== {1'b0, b.ch} || tl !== b.eos || tu !== b.last) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch: expected tdata %02h tlast %0b tuser %0b, got %02h %0b %0b",
                        {1'b0, b.ch}, b.eos, b.last, data, tl, tu);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   int             req_idle_pct = 0;
   int             rsp_idle_pct = 0;
   int             words_sent   = 0;
   int             runs_sent    = 0;
   text_scoreboard sb = new();

   packed_5bit_text_decoder_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_beat(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   function automatic logic [15:0] pack_word(logic [4:0] c0, logic [4:0] c1,
                                             logic [4:0] c2, logic eos);
      return {eos, c2, c1, c0};
   endfunction

   function automatic logic [4:0] rand_code();
      return ($urandom_range(7) == 0) ? CODE_TOGGLE : 5'($urandom_range(30));
   endfunction

   // called from clock-aligned code; valid stays high into the next word
   task automatic send_word(input logic [15:0] word);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sb.note_word(word);
      words_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic send_text_run();
      int          len;
      logic [15:0] w;
      len = $urandom_range(6, 1);
      for (int j = 0; j < len; j++) begin
         if ($urandom_range(9) == 0) begin
            w = 16'($urandom);
         end else begin
            w = pack_word(rand_code(), rand_code(), rand_code(), j == len - 1);
         end
         send_word(w);
      end
      runs_sent++;
   endtask

   initial begin
      logic [4:0] c [3];
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // terminated all-toggle word gives a bare terminator, then three spaces and a terminator
      send_word(16'hFFFF);
      send_word(16'h8000);
      // every code under both character sets, net toggles chosen to flip the set
      for (int pass = 0; pass < 2; pass++) begin
         for (int k = 0; k < 11; k++) begin
            for (int i = 0; i < 3; i++) begin
               c[i] = (3 * k + i > 30) ? CODE_TOGGLE : 5'(3 * k + i);
            end
            send_word(pack_word(c[0], c[1], c[2], k == 10));
         end
         send_word(16'h7FFF);
      end
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               req_idle_pct = 19;
               rsp_idle_pct = 83;
            end
            1: begin
               req_idle_pct = 83;
               rsp_idle_pct = 19;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         while (words_sent < 26 + 160 * (ph + 1)) begin
            send_text_run();
         end
         drain();
      end

      repeat (20) @(posedge clock);
      $display("Sent %0d words (%0d random runs) over three pacing phases;", words_sent,
               runs_sent);
      $display("checked %0d beats including %0d terminators, %0d errors, %0d left over",
               sb.beats_checked, sb.terminators, sb.errors, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d beats outstanding", sb.pending());
      $display("Some tests failed");
      $finish;
   end

endmodule
`default_nettype wire
